### rtl/lbpt_pkg.sv
// shared types and constants for the led breathing pwm throbber
package lbpt_pkg;

  // timing constants
  localparam int unsigned MAX_SPEED    = 30;
  localparam int unsigned WAIT_MAX_MS  = 5000;
  localparam int unsigned EVENT_MAX_S  = 1800;
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned PERIOD_RESET = 180;
  localparam int unsigned SAT_MS       = EVENT_MAX_S * MS_PER_S;

  localparam int unsigned ELAPSED_W = 11;
  localparam int unsigned SPEED_W   = 5;
  localparam int unsigned OFFSET_W  = 13;
  localparam int unsigned DIFF_W    = 21;

  // reciprocal multipliers: floor(x / 1000), floor(x / 60), floor(x * 25 / 9)
  localparam int unsigned MS_RECIP_SH     = 31;
  localparam logic [21:0] MS_RECIP        = 22'd2147484;
  localparam int unsigned SPEED_RECIP_SH  = 17;
  localparam logic [11:0] SPEED_RECIP     = 12'd2185;
  localparam int unsigned OFFSET_RECIP_SH = 16;
  localparam logic [17:0] OFFSET_RECIP    = 18'd182045;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic led_on;
    logic breathing;
  } out_item_t;

  typedef struct packed {
    logic                 mode;
    logic [31:0]          time_ms;
    logic [ELAPSED_W-1:0] elapsed;
  } mid_item_t;

endpackage

### rtl/lbpt_elapsed.sv
// input register, last event time and elapsed seconds stage
module lbpt_elapsed import lbpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      mid_valid,
  output mid_item_t mid_item
);

  logic                      s1_valid_r;
  in_item_t                  s1_item_r;
  logic [31:0]               last_event_r;
  logic                      mid_valid_r;
  mid_item_t                 mid_item_r;

  logic [31:0]               diff;
  logic                      sat;
  logic [DIFF_W+21:0]        q_prod;
  logic [ELAPSED_W-1:0]      elapsed;

  always_comb begin
    diff    = s1_item_r.time_ms - last_event_r;
    sat     = (last_event_r == 32'd0) || (diff >= 32'(SAT_MS));
    q_prod  = (DIFF_W+22)'(diff[DIFF_W-1:0]) * (DIFF_W+22)'(MS_RECIP);
    elapsed = sat ? ELAPSED_W'(EVENT_MAX_S)
                  : q_prod[MS_RECIP_SH+ELAPSED_W-1:MS_RECIP_SH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      mid_valid_r  <= 1'b0;
      last_event_r <= 32'd0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      mid_valid_r <= s1_valid_r;
      if (s1_valid_r && (s1_item_r.mode == MODE_EVENT)) begin
        last_event_r <= s1_item_r.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r          <= in_data;
      mid_item_r.mode    <= s1_item_r.mode;
      mid_item_r.time_ms <= s1_item_r.time_ms;
      mid_item_r.elapsed <= elapsed;
    end
  end

  assign mid_valid = mid_valid_r;
  assign mid_item  = mid_item_r;

endmodule

### rtl/lbpt_core.sv
// breathing phase state and result register
module lbpt_core import lbpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] period,
  input  logic       mid_valid,
  input  mid_item_t  mid_item,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic               phase_r, phase_nxt;
  logic [31:0]        exit_r, exit_nxt;
  logic [8:0]         pwm_r, pwm_nxt;
  logic signed [9:0]  bri_r, bri_nxt;
  logic signed [5:0]  inc_r, inc_nxt;
  logic               led_r, led_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [22:0]           spd_prod;
  logic [28:0]           off_prod;
  logic [SPEED_W-1:0]    speed;
  logic [OFFSET_W-1:0]   offset;
  logic signed [10:0]    per_s, pwm_s, bri_s;

  always_comb begin
    spd_prod = 23'(mid_item.elapsed) * 23'(SPEED_RECIP);
    off_prod = 29'(mid_item.elapsed) * 29'(OFFSET_RECIP);
    speed    = spd_prod[SPEED_RECIP_SH+SPEED_W-1:SPEED_RECIP_SH];
    if (speed == '0) begin
      speed = SPEED_W'(1);
    end
    offset   = off_prod[OFFSET_RECIP_SH+OFFSET_W-1:OFFSET_RECIP_SH];

    per_s = signed'({3'b000, period});
    phase_nxt = phase_r;
    exit_nxt  = exit_r;
    pwm_nxt   = pwm_r;
    bri_nxt   = bri_r;
    inc_nxt   = inc_r;
    led_nxt   = led_r;
    pwm_s     = '0;
    bri_s     = '0;

    if (mid_item.mode == MODE_TICK) begin
      if (!phase_r) begin
        if (mid_item.time_ms > exit_r) begin
          phase_nxt = 1'b1;
          pwm_nxt   = 9'd1;
          bri_nxt   = signed'(10'(speed));
          inc_nxt   = signed'(6'(speed));
        end
      end else begin
        led_nxt = signed'({2'b00, pwm_r}) < 11'(bri_r);
        pwm_s   = signed'({2'b00, pwm_r}) + 11'sd1;
        bri_s   = 11'(bri_r);
        if (pwm_s > per_s) begin
          pwm_s = 11'sd1;
          bri_s = bri_s + 11'(inc_r);
        end
        inc_nxt = inc_r;
        if (bri_s > per_s) begin
          bri_s   = per_s;
          inc_nxt = -inc_r;
        end
        pwm_nxt = pwm_s[8:0];
        bri_nxt = bri_s[9:0];
        if (bri_s < 11'sd1) begin
          led_nxt   = 1'b0;
          phase_nxt = 1'b0;
          exit_nxt  = mid_item.time_ms + 32'(WAIT_MAX_MS) - 32'(offset);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      exit_r      <= 32'd0;
      pwm_r       <= 9'd0;
      bri_r       <= 10'sd0;
      inc_r       <= 6'sd0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mid_valid;
      if (mid_valid) begin
        phase_r <= phase_nxt;
        exit_r  <= exit_nxt;
        pwm_r   <= pwm_nxt;
        bri_r   <= bri_nxt;
        inc_r   <= inc_nxt;
        led_r   <= led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.led_on    <= led_nxt;
      out_data_r.breathing <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/led_breathing_pwm_throbber_top.sv
// top level of the led breathing pwm throbber
//
// usage notes
// - input channel: in_valid / in_stall / in_data; a transaction moves when
//   in_valid is high and in_stall is low; mode 0 is a time tick, mode 1 marks
//   an event at time_ms
// - result channel: out_valid / out_stall / out_data; exactly one result per
//   input transaction, in order, giving the led level and breathing flag
// - configuration: cfg_we with cfg_wdata writes the pwm period (steps per
//   period and peak brightness); write it only while the block is idle
// - a result passes through the input, elapsed time and result registers
// - throughput: one transaction per cycle, back to back, unless a stalled
//   result holds the pipeline; the elapsed time and phase stages never iterate
// - the three register stages move together; while the receiver stalls a
//   pending result, in_stall is raised and everything holds
// - reset (synchronous, active low) empties the pipeline, selects the wait
//   phase with the led off, clears the event time and sets the period to 180
module led_breathing_pwm_throbber_top import lbpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] period_r;
  logic       en;
  logic       mid_valid;
  mid_item_t  mid_item;

  // the whole pipeline advances when the result slot is empty or being taken
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 8'(PERIOD_RESET);
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // input register and elapsed seconds since the last event
  lbpt_elapsed u_elapsed (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid_item  (mid_item)
  );

  // wait / active phase update and result register
  lbpt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .period    (period_r),
    .mid_valid (mid_valid),
    .mid_item  (mid_item),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
